// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is active.
`define TMDA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tmda assertion failed");

// Next-cycle implication, held off while reset is active.
`define TMDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tmda assertion failed");

// Next-cycle implication that also checks across reset.
`define TMDA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tmda assertion failed");

`endif

// ----- src/tmda_pkg.sv -----
// Shared constants and types for the tile map draw address block.
`default_nettype none

package tmda_pkg;

    localparam int NUM_TILESETS = 8;
    localparam int SET_W = (NUM_TILESETS > 1) ? $clog2(NUM_TILESETS) : 1;

    localparam int PITCH_W = 8;
    localparam int DIM_W   = 13;
    localparam int CNT_W   = 4;
    localparam int VIEW_W  = 8;
    localparam int ID_W    = 16;
    localparam int EIDX_W  = 3;
    localparam int COLS_W  = 10;
    localparam int DEST_W  = 16;
    localparam int SIDX_W  = 3;
    localparam int DIV_CNT_W = $clog2(ID_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_PITCH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILESET_COUNT = 2'd3;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_CELL = 1'b1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [DEST_W-1:0] dest_x;
        logic [DEST_W-1:0] dest_y;
        logic [ID_W-1:0]   diff;
        logic [COLS_W-1:0] ncol;
        logic [SIDX_W-1:0] set_index;
        logic              bad_id;
        logic              zero_res;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// ----- src/tmda_if.sv -----
// Handshake interfaces for the input and result channels.
`default_nettype none

interface tmda_in_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [tmda_pkg::VIEW_W-1:0]   view_row;
    logic [tmda_pkg::VIEW_W-1:0]   view_col;
    logic [tmda_pkg::ID_W-1:0]     tile_id;
    logic [tmda_pkg::EIDX_W-1:0]   entry_index;
    logic [tmda_pkg::ID_W-1:0]     first_id;
    logic [tmda_pkg::COLS_W-1:0]   set_columns;

    modport source (output valid, func, view_row, view_col, tile_id, entry_index,
                    first_id, set_columns, input ready);
    modport sink (input valid, func, view_row, view_col, tile_id, entry_index,
                  first_id, set_columns, output ready);
    modport mon (input valid, ready, func, view_row, view_col, tile_id, entry_index,
                 first_id, set_columns);
endinterface

interface tmda_out_if;
    logic                          valid;
    logic                          ready;
    logic [tmda_pkg::DEST_W-1:0]   dest_x;
    logic [tmda_pkg::DEST_W-1:0]   dest_y;
    logic [tmda_pkg::COLS_W-1:0]   src_column;
    logic [tmda_pkg::ID_W-1:0]     src_row;
    logic [tmda_pkg::SIDX_W-1:0]   set_index;
    logic                          bad_id;

    modport source (output valid, dest_x, dest_y, src_column, src_row, set_index,
                    bad_id, input ready);
    modport sink (input valid, dest_x, dest_y, src_column, src_row, set_index,
                  bad_id, output ready);
    modport mon (input valid, ready, dest_x, dest_y, src_column, src_row, set_index,
                 bad_id);
endinterface

`default_nettype wire

// ----- src/tmda_queue.sv -----
// Short job queue between the classify front end and the divide back end.
`default_nettype none

module tmda_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tmda_pkg::t_job      i_job,
    input  logic                i_pop,
    output tmda_pkg::t_q_status o_status,
    output tmda_pkg::t_job      o_job
);

    tmda_pkg::t_job                 r_mem [tmda_pkg::QDEPTH];
    logic [tmda_pkg::QPTR_W-1:0]    r_wp;
    logic [tmda_pkg::QPTR_W-1:0]    r_rp;
    logic [tmda_pkg::QCNT_W-1:0]    r_count;
    logic                           push_ok;
    logic                           pop_ok;

    assign o_status.full  = (r_count == tmda_pkg::QCNT_W'(tmda_pkg::QDEPTH));
    assign o_status.empty = (r_count == '0);
    assign push_ok = i_push && !o_status.full;
    assign pop_ok  = i_pop && !o_status.empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= (32'(r_wp) == tmda_pkg::QDEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (32'(r_rp) == tmda_pkg::QDEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/tmda_front.sv -----
// Front end: takes words, stores tileset entries, filters cells, picks a tileset.
`default_nettype none

module tmda_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    tmda_in_if.sink                         i_in,
    input  logic [tmda_pkg::PITCH_W-1:0]    i_tile_pitch,
    input  logic [tmda_pkg::DIM_W-1:0]      i_map_width,
    input  logic [tmda_pkg::DIM_W-1:0]      i_map_height,
    input  logic [tmda_pkg::CNT_W-1:0]      i_tileset_count,
    input  tmda_pkg::t_q_status             i_q_status,
    output logic                            o_push,
    output tmda_pkg::t_job                  o_job
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_SEL  = 2'd1;
    localparam logic [1:0] F_READ = 2'd2;

    logic [1:0]                     r_state;
    logic [1:0]                     n_state;
    logic [tmda_pkg::VIEW_W-1:0]    r_row;
    logic [tmda_pkg::VIEW_W-1:0]    r_col;
    logic [tmda_pkg::ID_W-1:0]      r_id;
    logic [tmda_pkg::SET_W-1:0]     r_sel;
    logic [tmda_pkg::SET_W-1:0]     n_sel;

    logic [tmda_pkg::ID_W-1:0]      r_first [tmda_pkg::NUM_TILESETS];
    logic [tmda_pkg::COLS_W-1:0]    r_cols  [tmda_pkg::NUM_TILESETS];

    logic                           accept;
    logic                           cell_hit;
    logic [tmda_pkg::SET_W-1:0]     last_idx;
    logic [tmda_pkg::ID_W-1:0]      base;
    logic [tmda_pkg::COLS_W-1:0]    ncol;

    assign i_in.ready = (r_state == F_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign cell_hit   = (tmda_pkg::DIM_W'(i_in.view_row) < i_map_height)
                     && (tmda_pkg::DIM_W'(i_in.view_col) < i_map_width)
                     && (i_in.tile_id != '0);

    // Count of zero acts as one, large counts saturate.
    always_comb begin
        if (i_tileset_count == '0) begin
            last_idx = '0;
        end else if (32'(i_tileset_count) > tmda_pkg::NUM_TILESETS) begin
            last_idx = tmda_pkg::SET_W'(tmda_pkg::NUM_TILESETS - 1);
        end else begin
            last_idx = tmda_pkg::SET_W'(i_tileset_count - tmda_pkg::CNT_W'(1));
        end
    end

    // Lowest matching range wins; the last entry in use catches the rest.
    always_comb begin
        n_sel = last_idx;
        for (int i = tmda_pkg::NUM_TILESETS - 2; i >= 0; i--) begin
            if ((i < 32'(last_idx)) && (r_id >= r_first[tmda_pkg::SET_W'(i)])
                && (r_id < r_first[tmda_pkg::SET_W'(i + 1)])) begin
                n_sel = tmda_pkg::SET_W'(i);
            end
        end
    end

    assign base = r_first[r_sel];
    assign ncol = r_cols[r_sel];

    always_comb begin
        o_job.dest_x    = tmda_pkg::DEST_W'(r_col) * tmda_pkg::DEST_W'(i_tile_pitch);
        o_job.dest_y    = tmda_pkg::DEST_W'(r_row) * tmda_pkg::DEST_W'(i_tile_pitch);
        o_job.diff      = r_id - base;
        o_job.ncol      = ncol;
        o_job.set_index = tmda_pkg::SIDX_W'(r_sel);
        o_job.bad_id    = (r_id < base);
        o_job.zero_res  = (r_id < base) || (ncol == '0);
    end

    assign o_push = (r_state == F_READ) && !i_q_status.full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept && (i_in.func == tmda_pkg::FUNC_CELL) && cell_hit) begin
                    n_state = F_SEL;
                end
            end
            F_SEL: begin
                n_state = F_READ;
            end
            F_READ: begin
                if (!i_q_status.full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row <= i_in.view_row;
            r_col <= i_in.view_col;
            r_id  <= i_in.tile_id;
        end
        if (r_state == F_SEL) begin
            r_sel <= n_sel;
        end
    end

    // Tileset table: loads with an index past the table are dropped.
    always_ff @(posedge i_clk) begin
        if (accept && (i_in.func == tmda_pkg::FUNC_LOAD)
            && (32'(i_in.entry_index) < tmda_pkg::NUM_TILESETS)) begin
            r_first[tmda_pkg::SET_W'(i_in.entry_index)] <= i_in.first_id;
            r_cols[tmda_pkg::SET_W'(i_in.entry_index)]  <= i_in.set_columns;
        end
    end

endmodule

`default_nettype wire

// ----- src/tmda_back.sv -----
// Back end: radix-2 restoring divider for source row/column and the result register.
`default_nettype none

module tmda_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tmda_pkg::t_q_status i_q_status,
    input  tmda_pkg::t_job      i_job,
    output logic                o_pop,
    tmda_out_if.source          o_out
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIV  = 2'd1;
    localparam logic [1:0] B_DONE = 2'd2;

    logic [1:0]                         r_state;
    logic [1:0]                         n_state;
    logic [tmda_pkg::DEST_W-1:0]        r_dest_x;
    logic [tmda_pkg::DEST_W-1:0]        r_dest_y;
    logic [tmda_pkg::SIDX_W-1:0]        r_set;
    logic                               r_bad;
    logic [tmda_pkg::COLS_W-1:0]        r_ncol;
    logic [tmda_pkg::ID_W-1:0]          r_q;
    logic [tmda_pkg::COLS_W-1:0]        r_rem;
    logic [tmda_pkg::DIV_CNT_W-1:0]     r_cnt;

    logic [tmda_pkg::COLS_W:0]          rem_sh;
    logic [tmda_pkg::COLS_W:0]          rem_sub;
    logic                               ge;

    assign o_pop   = (r_state == B_IDLE) && !i_q_status.empty;
    // Shift next dividend bit into the partial remainder; quotient bits fill r_q from below.
    assign rem_sh  = {r_rem, r_q[tmda_pkg::ID_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_ncol});
    assign rem_sub = rem_sh - {1'b0, r_ncol};

    assign o_out.valid      = (r_state == B_DONE);
    assign o_out.dest_x     = r_dest_x;
    assign o_out.dest_y     = r_dest_y;
    assign o_out.src_column = r_rem;
    assign o_out.src_row    = r_q;
    assign o_out.set_index  = r_set;
    assign o_out.bad_id     = r_bad;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    n_state = i_job.zero_res ? B_DONE : B_DIV;
                end
            end
            B_DIV: begin
                if (r_cnt == '0) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                if (o_out.ready) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dest_x <= i_job.dest_x;
            r_dest_y <= i_job.dest_y;
            r_set    <= i_job.set_index;
            r_bad    <= i_job.bad_id;
            r_ncol   <= i_job.ncol;
            r_q      <= i_job.zero_res ? '0 : i_job.diff;
            r_rem    <= '0;
            r_cnt    <= tmda_pkg::DIV_CNT_W'(tmda_pkg::ID_W - 1);
        end else if (r_state == B_DIV) begin
            r_q   <= {r_q[tmda_pkg::ID_W-2:0], ge};
            r_rem <= ge ? rem_sub[tmda_pkg::COLS_W-1:0] : rem_sh[tmda_pkg::COLS_W-1:0];
            r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- src/tile_map_draw_address.sv -----
// Top level of the tile map draw address block.
// Load words (func 0) write one tileset entry.
// Cell words (func 1) are checked against the map bounds and dropped when out of
// bounds or empty; otherwise the front end captures the word, selects the
// tileset range, reads the entry and multiplies by the pitch, and hands a job to
// a two-entry queue. The back end pops a job, runs a one-bit-per-cycle restoring
// divider and holds the result until taken. Cells with a bad id or zero column
// count skip the divider. The front end keeps taking words while the back end is
// busy, until the queue fills. Config writes take effect on the next cycle.
`default_nettype none

module tile_map_draw_address (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tmda_in_if.sink                             i_in,
    tmda_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [tmda_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tmda_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [tmda_pkg::PITCH_W-1:0]   r_tile_pitch;
    logic [tmda_pkg::DIM_W-1:0]     r_map_width;
    logic [tmda_pkg::DIM_W-1:0]     r_map_height;
    logic [tmda_pkg::CNT_W-1:0]     r_tileset_count;

    logic                           push;
    logic                           pop;
    tmda_pkg::t_job                 push_job;
    tmda_pkg::t_job                 pop_job;
    tmda_pkg::t_q_status            q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_pitch    <= tmda_pkg::PITCH_W'(32);
            r_map_width     <= tmda_pkg::DIM_W'(64);
            r_map_height    <= tmda_pkg::DIM_W'(64);
            r_tileset_count <= tmda_pkg::CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tmda_pkg::CFG_TILE_PITCH:    r_tile_pitch    <= i_cfg_data[tmda_pkg::PITCH_W-1:0];
                tmda_pkg::CFG_MAP_WIDTH:     r_map_width     <= i_cfg_data[tmda_pkg::DIM_W-1:0];
                tmda_pkg::CFG_MAP_HEIGHT:    r_map_height    <= i_cfg_data[tmda_pkg::DIM_W-1:0];
                tmda_pkg::CFG_TILESET_COUNT: r_tileset_count <= i_cfg_data[tmda_pkg::CNT_W-1:0];
            endcase
        end
    end

    tmda_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in            (i_in),
        .i_tile_pitch    (r_tile_pitch),
        .i_map_width     (r_map_width),
        .i_map_height    (r_map_height),
        .i_tileset_count (r_tileset_count),
        .i_q_status      (q_status),
        .o_push          (push),
        .o_job           (push_job)
    );

    tmda_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_status (q_status),
        .o_job    (pop_job)
    );

    tmda_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_job      (pop_job),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

// ----- src/tmda_checker.sv -----
// Port-level checker for the tile map draw address block, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module tmda_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_ready,
    input  logic [tmda_pkg::DEST_W-1:0]     i_dest_x,
    input  logic [tmda_pkg::ID_W-1:0]       i_src_row,
    input  logic [tmda_pkg::COLS_W-1:0]     i_src_column,
    input  logic                            i_bad_id
);

    `TMDA_ASSERT_NOW(a_bad_gives_zero, i_clk, i_rst_n, i_valid && i_bad_id,
                     (i_src_row == '0) && (i_src_column == '0))
    `TMDA_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_valid && !i_ready,
                      i_valid && $stable(i_src_row) && $stable(i_src_column)
                      && $stable(i_dest_x))
    `TMDA_ASSERT_NEXT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !i_valid)

endmodule

bind tile_map_draw_address tmda_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_dest_x     (o_out.dest_x),
    .i_src_row    (o_out.src_row),
    .i_src_column (o_out.src_column),
    .i_bad_id     (o_out.bad_id)
);

`default_nettype wire

// ----- dv/tile_map_draw_address_tb.sv -----
// Self-checking testbench for tile_map_draw_address: tileset loads, cell words, register settings.
`default_nettype none

module tile_map_draw_address_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASES        = 10;
    localparam int PHASE_WORDS   = 52;

    typedef struct packed {
        logic                          func;
        logic [tmda_pkg::VIEW_W-1:0]   view_row;
        logic [tmda_pkg::VIEW_W-1:0]   view_col;
        logic [tmda_pkg::ID_W-1:0]     tile_id;
        logic [tmda_pkg::EIDX_W-1:0]   entry_index;
        logic [tmda_pkg::ID_W-1:0]     first_id;
        logic [tmda_pkg::COLS_W-1:0]   set_columns;
    } t_tile_word;

    typedef struct packed {
        logic [tmda_pkg::DEST_W-1:0]   dest_x;
        logic [tmda_pkg::DEST_W-1:0]   dest_y;
        logic [tmda_pkg::COLS_W-1:0]   src_column;
        logic [tmda_pkg::ID_W-1:0]     src_row;
        logic [tmda_pkg::SIDX_W-1:0]   set_index;
        logic                          bad_id;
    } t_draw_addr;

    // Draw address predictor and queue of pending draw addresses.
    class tile_draw_scoreboard;
        logic [tmda_pkg::PITCH_W-1:0] tile_pitch;
        logic [tmda_pkg::DIM_W-1:0]   map_width;
        logic [tmda_pkg::DIM_W-1:0]   map_height;
        logic [tmda_pkg::CNT_W-1:0]   tileset_count;
        logic [tmda_pkg::ID_W-1:0]    first_ids [tmda_pkg::NUM_TILESETS];
        logic [tmda_pkg::COLS_W-1:0]  col_counts [tmda_pkg::NUM_TILESETS];
        t_draw_addr                   draws_due [$];
        int mismatches;
        int loads_seen;
        int cells_seen;
        int draws_checked;
        int bad_draws;

        function new();
            tile_pitch    = 8'd32;
            map_width     = 13'd64;
            map_height    = 13'd64;
            tileset_count = 4'd1;
            mismatches    = 0;
            loads_seen    = 0;
            cells_seen    = 0;
            draws_checked = 0;
            bad_draws     = 0;
        endfunction

        function void set_reg(logic [tmda_pkg::CFG_IDX_W-1:0] idx,
                              logic [tmda_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                tmda_pkg::CFG_TILE_PITCH:    tile_pitch    = data[tmda_pkg::PITCH_W-1:0];
                tmda_pkg::CFG_MAP_WIDTH:     map_width     = data[tmda_pkg::DIM_W-1:0];
                tmda_pkg::CFG_MAP_HEIGHT:    map_height    = data[tmda_pkg::DIM_W-1:0];
                tmda_pkg::CFG_TILESET_COUNT: tileset_count = data[tmda_pkg::CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int active_sets();
            if (tileset_count == 0)
                return 1;
            if (tileset_count > tmda_pkg::NUM_TILESETS)
                return tmda_pkg::NUM_TILESETS;
            return int'(tileset_count);
        endfunction

        function int pending();
            return draws_due.size();
        endfunction

        function void note_word(t_tile_word w);
            t_draw_addr                   d;
            int                           n;
            int                           sel;
            logic [tmda_pkg::ID_W-1:0]    base;
            logic [tmda_pkg::COLS_W-1:0]  ncol;
            logic [tmda_pkg::ID_W-1:0]    diff;
            if (w.func == tmda_pkg::FUNC_LOAD) begin
                loads_seen++;
                first_ids[w.entry_index]  = w.first_id;
                col_counts[w.entry_index] = w.set_columns;
                return;
            end
            cells_seen++;
            if (w.view_row >= map_height || w.view_col >= map_width || w.tile_id == 0)
                return;
            n   = active_sets();
            sel = n - 1;
            // descending scan so the lowest matching range wins
            for (int i = n - 2; i >= 0; i--) begin
                if (w.tile_id >= first_ids[i] && w.tile_id < first_ids[i + 1])
                    sel = i;
            end
            base         = first_ids[sel];
            ncol         = col_counts[sel];
            d.dest_x     = w.view_col * tile_pitch;
            d.dest_y     = w.view_row * tile_pitch;
            d.set_index  = sel[tmda_pkg::SIDX_W-1:0];
            d.bad_id     = 1'b0;
            d.src_row    = '0;
            d.src_column = '0;
            if (w.tile_id < base) begin
                d.bad_id = 1'b1;
            end else if (ncol != 0) begin
                diff         = w.tile_id - base;
                d.src_row    = diff / ncol;
                d.src_column = diff % ncol;
            end
            draws_due.push_back(d);
        endfunction

        function void check_result(t_draw_addr got);
            t_draw_addr want;
            draws_checked++;
            if (got.bad_id === 1'b1)
                bad_draws++;
            if (draws_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected draw word x=%0d y=%0d row=%0d col=%0d set=%0d bad=%0b",
                             got.dest_x, got.dest_y, got.src_row, got.src_column,
                             got.set_index, got.bad_id);
                return;
            end
            want = draws_due.pop_front();
            if (got.dest_x !== want.dest_x || got.dest_y !== want.dest_y
                    || got.src_column !== want.src_column || got.src_row !== want.src_row
                    || got.set_index !== want.set_index || got.bad_id !== want.bad_id) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: draw word %0d mismatch at %0t", draws_checked, $realtime);
                    $display("  exp x=%0d y=%0d row=%0d col=%0d set=%0d bad=%0b",
                             want.dest_x, want.dest_y, want.src_row, want.src_column,
                             want.set_index, want.bad_id);
                    $display("  got x=%0d y=%0d row=%0d col=%0d set=%0d bad=%0b",
                             got.dest_x, got.dest_y, got.src_row, got.src_column,
                             got.set_index, got.bad_id);
                end
            end
        endfunction
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [tmda_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [tmda_pkg::CFG_DATA_W-1:0] i_cfg_data;

    tmda_in_if  in_if ();
    tmda_out_if out_if ();

    tile_map_draw_address uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    tile_draw_scoreboard sb = new();

    int  cycle_count   = 0;
    int  hold_cycles   = 0;
    int  settings_used = 0;
    bit  sender_calm   = 1'b0;
    bit  receiver_calm = 1'b0;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ERROR: timeout after %0d cycles, %0d draw words pending",
                 cycle_count, sb.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stalls after each word, plus an optional long hold.
    initial begin : draw_sink
        int         stall;
        t_draw_addr got;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        out_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            stall = 0;
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.dest_x     = out_if.dest_x;
                got.dest_y     = out_if.dest_y;
                got.src_column = out_if.src_column;
                got.src_row    = out_if.src_row;
                got.set_index  = out_if.set_index;
                got.bad_id     = out_if.bad_id;
                sb.check_result(got);
                stall = receiver_calm ? 0 : $urandom_range(0, 13);
            end
            if (hold_cycles > 0) begin
                stall += hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                @(negedge i_clk);
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                out_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_word(input t_tile_word w);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_if.valid       <= 1'b1;
        in_if.func        <= w.func;
        in_if.view_row    <= w.view_row;
        in_if.view_col    <= w.view_col;
        in_if.tile_id     <= w.tile_id;
        in_if.entry_index <= w.entry_index;
        in_if.first_id    <= w.first_id;
        in_if.set_columns <= w.set_columns;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_word(w);
    endtask

    function automatic t_tile_word cell_word(int row, int col, int id);
        t_tile_word w;
        w.func        = tmda_pkg::FUNC_CELL;
        w.view_row    = row[tmda_pkg::VIEW_W-1:0];
        w.view_col    = col[tmda_pkg::VIEW_W-1:0];
        w.tile_id     = id[tmda_pkg::ID_W-1:0];
        w.entry_index = tmda_pkg::EIDX_W'($urandom_range(0, 7));
        w.first_id    = tmda_pkg::ID_W'($urandom_range(0, 65535));
        w.set_columns = tmda_pkg::COLS_W'($urandom_range(0, 1023));
        return w;
    endfunction

    function automatic t_tile_word load_word(int entry, int first, int cols);
        t_tile_word w;
        w.func        = tmda_pkg::FUNC_LOAD;
        w.view_row    = tmda_pkg::VIEW_W'($urandom_range(0, 255));
        w.view_col    = tmda_pkg::VIEW_W'($urandom_range(0, 255));
        w.tile_id     = tmda_pkg::ID_W'($urandom_range(0, 65535));
        w.entry_index = entry[tmda_pkg::EIDX_W-1:0];
        w.first_id    = first[tmda_pkg::ID_W-1:0];
        w.set_columns = cols[tmda_pkg::COLS_W-1:0];
        return w;
    endfunction

    // Drop valid and wait until every draw word is out, then let the pipe empty.
    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [tmda_pkg::CFG_IDX_W-1:0] idx, input int data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[tmda_pkg::CFG_DATA_W-1:0];
        sb.set_reg(idx, data[tmda_pkg::CFG_DATA_W-1:0]);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic write_all_regs(input int pitch, input int width, input int height,
                                  input int count);
        write_reg(tmda_pkg::CFG_TILE_PITCH, pitch);
        write_reg(tmda_pkg::CFG_MAP_WIDTH, width);
        write_reg(tmda_pkg::CFG_MAP_HEIGHT, height);
        write_reg(tmda_pkg::CFG_TILESET_COUNT, count);
        settings_used++;
    endtask

    // Ascending first ids so range selection behaves as in a real map.
    task automatic load_sorted_sets(input int step_max);
        int first;
        int cols;
        first = $urandom_range(1, 300);
        for (int e = 0; e < tmda_pkg::NUM_TILESETS; e++) begin
            cols = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(0, 1023);
            send_word(load_word(e, first, cols));
            first += $urandom_range(1, step_max);
            if (first > 65535)
                first = 65535;
        end
    endtask

    initial begin : stimulus
        int r;
        int n;
        int sel;
        int lo;
        int hi;
        int row_max;
        int col_max;
        int pitch;
        int width;
        int height;
        int count;
        int leftover;
        t_tile_word w;

        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = tmda_pkg::CFG_TILE_PITCH;
        i_cfg_data        = '0;
        in_if.valid       = 1'b0;
        in_if.func        = tmda_pkg::FUNC_LOAD;
        in_if.view_row    = '0;
        in_if.view_col    = '0;
        in_if.tile_id     = '0;
        in_if.entry_index = '0;
        in_if.first_id    = '0;
        in_if.set_columns = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: fixed table, reset register values first
        sender_calm = 1'b1;
        send_word(load_word(0, 1, 1));
        send_word(load_word(1, 100, 1023));
        send_word(load_word(2, 1000, 7));
        send_word(load_word(3, 5000, 0));
        send_word(load_word(4, 20000, 16));
        send_word(load_word(5, 40000, 100));
        send_word(load_word(6, 60000, 3));
        send_word(load_word(7, 65535, 1));
        send_word(cell_word(0, 0, 1));
        send_word(cell_word(63, 63, 65535));
        send_word(cell_word(64, 0, 5));
        send_word(cell_word(0, 64, 5));
        send_word(cell_word(10, 10, 0));
        settle();

        write_all_regs(255, 256, 256, 8);
        send_word(cell_word(255, 255, 65535));
        send_word(cell_word(0, 0, 1));
        send_word(cell_word(128, 7, 999));
        send_word(cell_word(3, 200, 1234));
        send_word(cell_word(9, 9, 5001));       // zero column count
        send_word(cell_word(1, 2, 25000));
        send_word(cell_word(4, 4, 60001));
        // raise entry 0 so low ids fall to the last entry and below its first id
        send_word(load_word(0, 50, 5));
        send_word(cell_word(5, 5, 10));
        send_word(cell_word(255, 0, 49));
        settle();

        write_all_regs(0, 256, 256, 0);         // pitch zero, count zero acts as one
        send_word(cell_word(200, 100, 300));
        settle();
        write_reg(tmda_pkg::CFG_TILESET_COUNT, 15);       // saturates to all entries
        send_word(cell_word(17, 18, 65535));
        settle();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin pitch = 255; width = 256; height = 256; count = 8; end
                1: begin pitch = 1; width = 1; height = 1; count = 1; end
                2: begin pitch = 0; width = 8191; height = 8191; count = 15; end
                3: begin
                    pitch  = $urandom_range(0, 255);
                    width  = $urandom_range(1, 40);
                    height = $urandom_range(1, 40);
                    count  = 0;
                end
                4: begin
                    pitch = $urandom_range(0, 255);
                    width = 4096; height = 4096;
                    count = $urandom_range(1, 8);
                end
                5: begin pitch = 32; width = 64; height = 64; count = 1; end
                6: begin
                    pitch = $urandom_range(0, 255);
                    width = 0; height = 200;
                    count = $urandom_range(0, 15);
                end
                default: begin
                    pitch  = $urandom_range(0, 255);
                    width  = $urandom_range(0, 1) ? $urandom_range(1, 300)
                                                  : $urandom_range(0, 8191);
                    height = $urandom_range(0, 1) ? $urandom_range(1, 300)
                                                  : $urandom_range(0, 8191);
                    count  = $urandom_range(0, 15);
                end
            endcase
            sender_calm   = (p % 3 == 0);
            receiver_calm = (p % 4 == 1);
            write_all_regs(pitch, width, height, count);
            load_sorted_sets((p % 2 == 1) ? 9000 : 400);

            row_max = (sb.map_height == 0) ? 255 : ((sb.map_height > 256) ? 255
                                                                           : sb.map_height - 1);
            col_max = (sb.map_width == 0) ? 255 : ((sb.map_width > 256) ? 255
                                                                         : sb.map_width - 1);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                // long output hold while words keep coming, fills the job queue
                if (p == 0 && k == 6)
                    hold_cycles = 300;
                // sender waits for a fully drained pipe once
                if (p == 4 && k == 30) begin
                    @(negedge i_clk);
                    in_if.valid <= 1'b0;
                    while (sb.pending() != 0) @(posedge i_clk);
                end
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    n   = sb.active_sets();
                    sel = $urandom_range(0, n - 1);
                    lo  = sb.first_ids[sel];
                    if (sel < n - 1 && sb.first_ids[sel + 1] > lo)
                        hi = sb.first_ids[sel + 1] - 1;
                    else
                        hi = (lo + 5000 > 65535) ? 65535 : lo + 5000;
                    w = cell_word($urandom_range(0, row_max), $urandom_range(0, col_max),
                                  $urandom_range(lo, hi));
                end else if (r < 78) begin
                    w = cell_word($urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 65535));
                end else if (r < 84) begin
                    w = cell_word($urandom_range(0, row_max), $urandom_range(0, col_max), 0);
                end else if (r < 90) begin
                    if (sb.map_height < 256 && $urandom_range(0, 1))
                        w = cell_word($urandom_range(sb.map_height, 255),
                                      $urandom_range(0, 255), $urandom_range(1, 65535));
                    else if (sb.map_width < 256)
                        w = cell_word($urandom_range(0, 255),
                                      $urandom_range(sb.map_width, 255),
                                      $urandom_range(1, 65535));
                    else
                        w = cell_word($urandom_range(0, 255), $urandom_range(0, 255),
                                      $urandom_range(1, 65535));
                end else begin
                    w = load_word($urandom_range(0, 7), $urandom_range(0, 65535),
                                  $urandom_range(0, 1023));
                end
                send_word(w);
            end
            settle();
        end

        leftover = sb.pending();
        if (leftover != 0)
            $display("ERROR: %0d draw words never arrived", leftover);
        $display("Run: %0d tileset loads and %0d cells sent, %0d draw words checked (%0d bad id)",
                 sb.loads_seen, sb.cells_seen, sb.draws_checked, sb.bad_draws);
        $display("     over %0d register settings, %0d mismatches",
                 settings_used, sb.mismatches);
        if (sb.mismatches == 0 && leftover == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
